[src/csr_pkg.sv]
// ----------------------------------------------------------------------------
// csr_pkg
// shared types and constants of the can segment reassembler
// ----------------------------------------------------------------------------
package csr_pkg;

	// number of 7-byte chunks the store can hold, 1 to 31
	localparam int MAX_CHUNKS  = 18;
	localparam int ADDR_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int NUM_W       = 6;
	localparam int IDX_W       = 5;
	localparam int CHUNK_W     = 56;
	localparam int BYTE_W      = 8;

	localparam logic [IDX_W-1:0]  MAX_NUM     = IDX_W'(MAX_CHUNKS);
	localparam logic [BYTE_W-1:0] CHUNK_BYTES = 8'd7;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] data_byte_0;
		logic [7:0] data_byte_1;
		logic [7:0] data_byte_2;
		logic [7:0] data_byte_3;
		logic [7:0] data_byte_4;
		logic [7:0] data_byte_5;
		logic [7:0] data_byte_6;
	} frame_beat_t;

	typedef struct packed {
		logic [4:0] chunk_index;
		logic [7:0] out_byte_0;
		logic [7:0] out_byte_1;
		logic [7:0] out_byte_2;
		logic [7:0] out_byte_3;
		logic [7:0] out_byte_4;
		logic [7:0] out_byte_5;
		logic [7:0] out_byte_6;
		logic [7:0] total_bytes;
		logic       last_chunk;
	} chunk_beat_t;

	// write request into the chunk store
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CHUNK_W-1:0] data;
	} chunk_wr_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

[src/csr_chunk_store.sv]
// ----------------------------------------------------------------------------
// csr_chunk_store
// chunk memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module csr_chunk_store (
	input  logic                          clk,
	input  csr_pkg::chunk_wr_t            wr,
	input  logic                          rd_en,
	input  logic [csr_pkg::ADDR_W-1:0]    rd_addr,
	output logic [csr_pkg::CHUNK_W-1:0]   rd_data
);

	logic [csr_pkg::CHUNK_W-1:0] mem [csr_pkg::MAX_CHUNKS];
	logic [csr_pkg::CHUNK_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/can_segment_reassembler_core.sv]
// ----------------------------------------------------------------------------
// can_segment_reassembler_core
// rebuilds a multi-frame message from 8-byte bus frames and emits its chunks
// ----------------------------------------------------------------------------
// A frame beat that does not complete a message is accepted while the block
// is idle: its header is checked against the receive state and its seven data
// bytes are written as one chunk into the chunk store. A frame that ends a
// message of N chunks (N = 1 to 18) holds frame_ready low while the chunks
// are read back in order, one per cycle through the single read port of the
// store, and then takes frames again; the chunk beats leave through a
// two-stage output path (memory read register, then output register), and
// back-pressure on chunk_ready slows the read-out to the rate the sink takes
// beats. Headers with number zero are dropped; unexpected numbers, numbers
// beyond the store and end frames that would overflow it abort the message
// without output. No clearing pass is needed after reset: only chunks
// written by the current message are ever read.
module can_segment_reassembler_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_ready,
	input  csr_pkg::frame_beat_t frame,
	output logic                 chunk_valid,
	input  logic                 chunk_ready,
	output csr_pkg::chunk_beat_t chunk
);

	// receive state
	logic                               receiving_q, receiving_d;
	logic [csr_pkg::IDX_W-1:0]          expected_q, expected_d;
	logic [csr_pkg::BYTE_W-1:0]         byte_count_q, byte_count_d;

	// drain control
	csr_pkg::state_t                    state_q, state_d;
	logic [csr_pkg::IDX_W-1:0]          rd_idx_q;
	logic [csr_pkg::IDX_W-1:0]          last_idx_q;
	logic [csr_pkg::IDX_W-1:0]          drain_last;
	logic                               start_drain;
	logic                               rd_issue;

	// frame decode
	logic                               frame_acc;
	logic [csr_pkg::NUM_W-1:0]          num;
	logic [csr_pkg::IDX_W-1:0]          num_lo;
	logic                               end_flag;
	logic [csr_pkg::IDX_W-1:0]          exp_m1;
	logic [csr_pkg::IDX_W-1:0]          num_m1;
	csr_pkg::chunk_wr_t                 wr;

	// read pipeline
	logic [csr_pkg::CHUNK_W-1:0]        rd_data;
	logic                               s1_valid_q;
	logic [csr_pkg::IDX_W-1:0]          s1_index_q;
	logic                               s1_last_q;
	logic [csr_pkg::BYTE_W-1:0]         s1_total_q;
	logic                               s1_move;
	logic                               s1_free;
	logic                               chunk_valid_q;
	csr_pkg::chunk_beat_t               chunk_q;

	assign frame_acc = frame_valid && frame_ready;
	assign num       = frame.header_byte[7:2];
	assign num_lo    = num[csr_pkg::IDX_W-1:0];
	assign end_flag  = num[csr_pkg::NUM_W-1];
	assign exp_m1    = expected_q - 1'b1;
	assign num_m1    = num_lo - 1'b1;

	// header check against the receive state, store write and drain start
	always_comb begin
		receiving_d  = receiving_q;
		expected_d   = expected_q;
		byte_count_d = byte_count_q;
		wr.en        = 1'b0;
		wr.addr      = '0;
		wr.data      = {frame.data_byte_6, frame.data_byte_5, frame.data_byte_4,
			frame.data_byte_3, frame.data_byte_2, frame.data_byte_1,
			frame.data_byte_0};
		start_drain  = 1'b0;
		drain_last   = '0;
		if (frame_acc && (num != '0)) begin
			if (receiving_q) begin
				if (num == {1'b0, expected_q}) begin
					if (num_lo > csr_pkg::MAX_NUM) begin
						// number beyond the store
						receiving_d  = 1'b0;
						expected_d   = csr_pkg::IDX_W'(1);
						byte_count_d = '0;
					end else begin
						wr.en        = 1'b1;
						wr.addr      = num_m1[csr_pkg::ADDR_W-1:0];
						expected_d   = expected_q + 1'b1;
						byte_count_d = byte_count_q + csr_pkg::CHUNK_BYTES;
					end
				end else if (end_flag) begin
					if (exp_m1 >= csr_pkg::MAX_NUM) begin
						// final chunk would not fit
						receiving_d  = 1'b0;
						expected_d   = csr_pkg::IDX_W'(1);
						byte_count_d = '0;
					end else begin
						wr.en        = 1'b1;
						wr.addr      = exp_m1[csr_pkg::ADDR_W-1:0];
						byte_count_d = byte_count_q + {3'b000, num_lo};
						receiving_d  = 1'b0;
						expected_d   = csr_pkg::IDX_W'(1);
						start_drain  = 1'b1;
						drain_last   = exp_m1;
					end
				end else begin
					// out of sequence
					receiving_d  = 1'b0;
					expected_d   = csr_pkg::IDX_W'(1);
					byte_count_d = '0;
				end
			end else begin
				if (num == csr_pkg::NUM_W'(1)) begin
					// start of a message
					wr.en        = 1'b1;
					receiving_d  = 1'b1;
					expected_d   = csr_pkg::IDX_W'(2);
					byte_count_d = csr_pkg::CHUNK_BYTES;
				end else if (end_flag) begin
					// single-frame message
					wr.en        = 1'b1;
					byte_count_d = {3'b000, num_lo};
					receiving_d  = 1'b0;
					expected_d   = csr_pkg::IDX_W'(1);
					start_drain  = 1'b1;
				end else begin
					receiving_d  = 1'b0;
					expected_d   = csr_pkg::IDX_W'(1);
					byte_count_d = '0;
				end
			end
		end
	end

	// read-out pipeline moves
	assign s1_move = s1_valid_q && (!chunk_valid_q || chunk_ready);
	assign s1_free = !s1_valid_q || s1_move;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			csr_pkg::ST_IDLE: begin
				if (start_drain) begin
					state_d = csr_pkg::ST_DRAIN;
				end
			end
			csr_pkg::ST_DRAIN: begin
				if (rd_issue && (rd_idx_q == last_idx_q)) begin
					state_d = csr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csr_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		frame_ready = 1'b0;
		rd_issue    = 1'b0;
		case (state_q)
			csr_pkg::ST_IDLE: begin
				frame_ready = 1'b1;
			end
			csr_pkg::ST_DRAIN: begin
				rd_issue = s1_free;
			end
			default: begin
				frame_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q  <= 1'b0;
			expected_q   <= csr_pkg::IDX_W'(1);
			byte_count_q <= '0;
			state_q      <= csr_pkg::ST_IDLE;
			rd_idx_q     <= '0;
			last_idx_q   <= '0;
		end else begin
			receiving_q  <= receiving_d;
			expected_q   <= expected_d;
			byte_count_q <= byte_count_d;
			state_q      <= state_d;
			if (start_drain) begin
				rd_idx_q   <= '0;
				last_idx_q <= drain_last;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	csr_chunk_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_issue),
		.rd_addr (rd_idx_q[csr_pkg::ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// beat info that travels alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rd_issue) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			s1_index_q <= rd_idx_q;
			s1_last_q  <= (rd_idx_q == last_idx_q);
			s1_total_q <= byte_count_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_valid_q <= 1'b0;
		end else if (s1_move) begin
			chunk_valid_q <= 1'b1;
		end else if (chunk_ready) begin
			chunk_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			chunk_q.chunk_index <= s1_index_q;
			chunk_q.out_byte_0  <= rd_data[7:0];
			chunk_q.out_byte_1  <= rd_data[15:8];
			chunk_q.out_byte_2  <= rd_data[23:16];
			chunk_q.out_byte_3  <= rd_data[31:24];
			chunk_q.out_byte_4  <= rd_data[39:32];
			chunk_q.out_byte_5  <= rd_data[47:40];
			chunk_q.out_byte_6  <= rd_data[55:48];
			chunk_q.total_bytes <= s1_total_q;
			chunk_q.last_chunk  <= s1_last_q;
		end
	end

	assign chunk_valid = chunk_valid_q;
	assign chunk       = chunk_q;

endmodule

[verif/reassembly_checker.sv]
// ----------------------------------------------------------------------------
// reassembly_checker
// watches both channels, rebuilds each message itself and checks every chunk
// ----------------------------------------------------------------------------
module reassembly_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	input  logic                 frame_ready,
	input  csr_pkg::frame_beat_t frame,
	input  logic                 chunk_valid,
	input  logic                 chunk_ready,
	input  csr_pkg::chunk_beat_t chunk,
	output int                   fails,
	output int                   pending,
	output int                   chunks_checked,
	output int                   messages_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// own copy of the receive state
	logic                 rx_active;
	logic [4:0]           next_number;
	logic [7:0]           msg_bytes;
	logic [55:0]          shadow_store [csr_pkg::MAX_CHUNKS];
	csr_pkg::chunk_beat_t expected_chunks [$];

	task automatic drop_message();
		rx_active   = 1'b0;
		next_number = 5'd1;
		msg_bytes   = 8'd0;
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			fails++;
			$display("%0t ns: chunk %s mismatch, expected %0h actual %0h",
				$time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		csr_pkg::chunk_beat_t want;
		logic [5:0]  number;
		logic [4:0]  last_idx;
		logic [55:0] payload;
		int          n_out;
		if (!arst_n) begin
			drop_message();
			expected_chunks.delete();
			pending = 0;
		end else begin
			if (chunk_valid && chunk_ready) begin
				chunks_checked++;
				if (expected_chunks.size() == 0) begin
					fails++;
					$display("%0t ns: unexpected chunk beat, expected none actual %h",
						$time, chunk);
				end else begin
					want = expected_chunks.pop_front();
					if (want.last_chunk)
						messages_checked++;
					check_field("chunk_index", want.chunk_index, chunk.chunk_index);
					check_field("out_byte_0", want.out_byte_0, chunk.out_byte_0);
					check_field("out_byte_1", want.out_byte_1, chunk.out_byte_1);
					check_field("out_byte_2", want.out_byte_2, chunk.out_byte_2);
					check_field("out_byte_3", want.out_byte_3, chunk.out_byte_3);
					check_field("out_byte_4", want.out_byte_4, chunk.out_byte_4);
					check_field("out_byte_5", want.out_byte_5, chunk.out_byte_5);
					check_field("out_byte_6", want.out_byte_6, chunk.out_byte_6);
					check_field("total_bytes", want.total_bytes, chunk.total_bytes);
					check_field("last_chunk", want.last_chunk, chunk.last_chunk);
				end
			end
			if (frame_valid && frame_ready) begin
				number  = frame.header_byte[7:2];
				payload = {frame.data_byte_0, frame.data_byte_1, frame.data_byte_2,
					frame.data_byte_3, frame.data_byte_4, frame.data_byte_5,
					frame.data_byte_6};
				n_out   = 0;
				if (number == 6'd0) begin
					// no packet, frame dropped
				end else if (rx_active) begin
					if (number == {1'b0, next_number}) begin
						if (number > csr_pkg::MAX_CHUNKS) begin
							drop_message();
						end else begin
							shadow_store[number - 1] = payload;
							next_number = next_number + 5'd1;
							msg_bytes   = msg_bytes + 8'd7;
						end
					end else if (number[5]) begin
						last_idx = next_number - 5'd1;
						if (last_idx >= csr_pkg::MAX_CHUNKS) begin
							drop_message();
						end else begin
							shadow_store[last_idx] = payload;
							msg_bytes   = msg_bytes + {3'd0, number[4:0]};
							rx_active   = 1'b0;
							next_number = 5'd1;
							n_out       = last_idx + 1;
						end
					end else begin
						drop_message();
					end
				end else if (number == 6'd1) begin
					shadow_store[0] = payload;
					rx_active   = 1'b1;
					next_number = 5'd2;
					msg_bytes   = 8'd7;
				end else if (number[5]) begin
					shadow_store[0] = payload;
					msg_bytes   = {3'd0, number[4:0]};
					next_number = 5'd1;
					n_out       = 1;
				end else begin
					drop_message();
				end
				for (int k = 0; k < n_out; k++) begin
					want.chunk_index = 5'(k);
					{want.out_byte_0, want.out_byte_1, want.out_byte_2, want.out_byte_3,
						want.out_byte_4, want.out_byte_5, want.out_byte_6} = shadow_store[k];
					want.total_bytes = msg_bytes;
					want.last_chunk  = (k == n_out - 1);
					expected_chunks.push_back(want);
				end
			end
			pending = expected_chunks.size();
		end
	end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the can segment reassembler core
// ----------------------------------------------------------------------------
// Frames are offered on the frame channel: a directed opening covers dropped
// headers, single-frame messages, aborts and restarts, then random messages of
// mostly well-formed numbering with random data, plus broken sequences, noise,
// full-store messages and store overruns. The sink idles in random bursts and
// once stalls for a long stretch so the block backs up into the frame channel.
// A separate checker predicts every chunk beat and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_FRAMES = 140;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 frame_valid;
	logic                 frame_ready;
	csr_pkg::frame_beat_t frame;
	logic                 chunk_valid;
	logic                 chunk_ready;
	csr_pkg::chunk_beat_t chunk;

	int fails;
	int pending;
	int chunks_checked;
	int messages_checked;

	// stimulus bookkeeping, partly shared with the sink process
	int   frames_sent;
	int   directed_frames;
	int   cycles;
	logic calm;
	logic hold_go;
	logic hold_done;

	can_segment_reassembler_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.chunk_valid (chunk_valid),
		.chunk_ready (chunk_ready),
		.chunk       (chunk)
	);

	reassembly_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.frame_valid      (frame_valid),
		.frame_ready      (frame_ready),
		.frame            (frame),
		.chunk_valid      (chunk_valid),
		.chunk_ready      (chunk_ready),
		.chunk            (chunk),
		.fails            (fails),
		.pending          (pending),
		.chunks_checked   (chunks_checked),
		.messages_checked (messages_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chunk beats outstanding", cycles, pending);
			$display("[can_segment_reassembler_core] ERROR");
			$finish;
		end
	end

	function automatic logic [55:0] rand_payload();
		return 56'({$urandom, $urandom});
	endfunction

	// one frame beat; an occasional gap with frame_valid low goes before it
	task automatic send_frame(input logic [5:0] number, input logic [1:0] spare,
		input logic [55:0] payload);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			frame_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		frame_valid <= 1'b1;
		frame       <= {number, spare, payload};
		do @(posedge clk); while (!frame_ready);
		if (number != 6'd0)
			frames_sent++;
	endtask

	// packet numbers 1..upto in order, with the odd dropped header in between
	task automatic send_run(input int upto);
		for (int i = 1; i <= upto; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_frame(6'd0, 2'($urandom_range(0, 3)), rand_payload());
			send_frame(6'(i), 2'($urandom_range(0, 3)), rand_payload());
		end
	endtask

	// end frame: bit 5 set, low bits give the final length
	task automatic send_end(input int len);
		send_frame(6'(32 + len), 2'($urandom_range(0, 3)), rand_payload());
	endtask

	// sink: random ready bursts, one long hold on request, always ready when calm
	initial begin
		chunk_ready = 1'b0;
		hold_done   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				chunk_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				chunk_ready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				chunk_ready <= 1'b1;
				if (!calm)
					repeat ($urandom_range(0, 12)) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int random_target;
		int pick;
		arst_n      = 1'b0;
		frame_valid = 1'b0;
		frame       = '0;
		frames_sent = 0;
		calm        = 1'b0;
		hold_go     = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// --- directed opening ---
		// dropped header, spare bits set, all-ones data
		send_frame(6'd0, 2'b11, {56{1'b1}});
		// single-frame messages at both length extremes
		send_frame(6'd32, 2'b00, 56'd0);
		send_frame(6'd63, 2'b11, {56{1'b1}});
		// stray middle number while idle
		send_frame(6'd5, 2'b01, rand_payload());
		// two-frame message
		send_frame(6'd1, 2'b10, {56{1'b1}});
		send_frame(6'd35, 2'b00, 56'd0);
		// wrong number aborts, then a fresh single-frame message
		send_frame(6'd1, 2'b00, rand_payload());
		send_frame(6'd2, 2'b00, rand_payload());
		send_frame(6'd7, 2'b00, rand_payload());
		send_frame(6'd33, 2'b00, rand_payload());
		// start repeated while receiving aborts without restarting
		send_frame(6'd1, 2'b00, rand_payload());
		send_frame(6'd1, 2'b00, rand_payload());
		send_frame(6'd2, 2'b00, rand_payload());
		send_frame(6'd36, 2'b00, rand_payload());
		// dropped header inside a message, maximum end length
		send_frame(6'd1, 2'b01, rand_payload());
		send_frame(6'd0, 2'b10, rand_payload());
		send_frame(6'd2, 2'b11, rand_payload());
		send_frame(6'd3, 2'b00, rand_payload());
		send_frame(6'd63, 2'b01, rand_payload());
		directed_frames = frames_sent;

		// --- random part ---
		// full store under a long sink stall, then both overrun cases
		hold_go = 1'b1;
		send_run(17);
		send_end($urandom_range(0, 31));
		send_run(18);
		send_end($urandom_range(0, 31));
		send_run(19);
		send_end($urandom_range(0, 31));

		random_target = directed_frames + RANDOM_FRAMES;
		while (frames_sent < random_target) begin
			// quiet tail: no idling on either side
			if (frames_sent >= random_target - 30)
				calm = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send_frame(6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)), rand_payload());
			end else if (pick == 1) begin
				// broken sequence: a middle number that usually does not fit
				send_run($urandom_range(1, 6));
				send_frame(6'($urandom_range(1, 31)), 2'($urandom_range(0, 3)), rand_payload());
			end else if (pick == 2) begin
				send_run($urandom_range(15, 19));
				send_end($urandom_range(0, 31));
			end else begin
				send_run($urandom_range(0, 6));
				send_end($urandom_range(0, 31));
			end
		end
		@(negedge clk);
		frame_valid <= 1'b0;

		// drain, then keep watching for anything stray
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("frame beats: %0d (%0d directed), chunk beats checked: %0d in %0d messages",
			frames_sent, directed_frames, chunks_checked, messages_checked);
		$display("covered single-frame and full-store messages, overruns, aborts, a %0d-cycle stall",
			HOLD_CYCLES);
		if (pending != 0)
			$display("%0d expected chunk beats never arrived", pending);
		if (fails == 0 && pending == 0)
			$display("[can_segment_reassembler_core] OK");
		else
			$display("[can_segment_reassembler_core] ERROR");
		$finish;
	end

endmodule
